[rtl/timed_output_phase_sequencer_unit_defines.svh]
// ----------------------------------------------------------------------------
// timed output phase sequencer assertion macros
// assertion wrappers, empty when the design is built for synthesis
// ----------------------------------------------------------------------------
`ifndef TIMED_OUTPUT_PHASE_SEQUENCER_UNIT_DEFINES_SVH
`define TIMED_OUTPUT_PHASE_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define TOPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define TOPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TOPS_ASSERT(label, prop, msg)
`define TOPS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/tops_pkg.sv]
// ----------------------------------------------------------------------------
// tops_pkg
// shared types, codes and sizes of the timed output phase sequencer
// ----------------------------------------------------------------------------
package tops_pkg;

  localparam int MAX_PHASES = 64;
  localparam int ACTUATORS  = 8;

  localparam int PTR_W    = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int TOTAL_W  = $clog2(MAX_PHASES + 1);
  localparam int LINE_W   = 8;
  localparam int PERIOD_W = 16;
  localparam int ENTRY_W  = LINE_W + PERIOD_W;
  localparam int DRIVE_W  = 8;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_BUSY  = 2'd3;

  // program characters
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PHASE = 2'd1,
    MODE_GAP   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    FS_WAIT   = 2'd0,
    FS_DIGITS = 2'd1,
    FS_DONE   = 2'd2
  } field_st_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] program_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] actuator_drive;
    logic       busy_res;
    logic       run_done;
    logic [5:0] current_phase;
    logic [6:0] stored_phases;
    logic [1:0] status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic fetch_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_fetch;
  } dp_sts_t;

endpackage

[rtl/timed_output_phase_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// timed_output_phase_sequencer_unit
// loads a [line:period] program and steps actuators through it on ticks
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one beat per command: begin load, program byte, start run
//   or one millisecond tick; each beat yields exactly one result beat on
//   out_* with the actuator mask, run flags, phase index, phase count and
//   status. cfg_we/cfg_wdata sets the gap between phases; write it only
//   while the block is idle.
// sequencing:
//   one beat at a time; the result of a beat with no table read is valid
//   from the cycle after it is taken. start with a stored program and the
//   tick that moves to the next phase read the phase table ram, which adds
//   the fetch state before the result. the next beat is taken the cycle
//   after the result beat leaves.
// reset:
//   rst_n (synchronous) empties the program, stops any run and clears the
//   gap register; the table ram itself is not cleared, only rows below the
//   phase count are ever read.
// stall:
//   while out_ready is low the result holds and in_ready stays low.
// ----------------------------------------------------------------------------
`include "timed_output_phase_sequencer_unit_defines.svh"

module timed_output_phase_sequencer_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  // command beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tops_pkg::in_item_t   in_data,
  // result beats
  output logic                 out_valid,
  input  logic                 out_ready,
  output tops_pkg::out_item_t  out_data,
  // gap register write
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);
  import tops_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencing: accept, optional table read, result hold
  tops_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd)
  );

  // parser, phase table, tick timer; result fields come from its registers
  tops_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_i     (dp_cmd),
    .sts_o     (dp_sts),
    .res_o     (out_data)
  );

  // the block never takes a beat while a result is pending
  `TOPS_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken with result pending")

endmodule

[rtl/tops_ram.sv]
// ----------------------------------------------------------------------------
// tops_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tops_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tops_dp.sv]
// ----------------------------------------------------------------------------
// tops_dp
// datapath: program parser, phase table, run timer and result fields
// ----------------------------------------------------------------------------
`include "timed_output_phase_sequencer_unit_defines.svh"

module tops_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  tops_pkg::in_item_t in_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  tops_pkg::dp_cmd_t  cmd_i,
  output tops_pkg::dp_sts_t  sts_o,
  output tops_pkg::out_item_t res_o
);
  import tops_pkg::*;

  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [LINE_W-1:0]   line_acc_r, line_acc_nxt;
  logic [PERIOD_W-1:0] period_acc_r, period_acc_nxt;
  logic                period_sel_r, period_sel_nxt;
  field_st_t           line_st_r, line_st_nxt;
  field_st_t           period_st_r, period_st_nxt;
  mode_t               mode_r, mode_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic [PERIOD_W-1:0] ticks_r, ticks_nxt;
  logic [PERIOD_W-1:0] delay_r;
  logic [LINE_W-1:0]   cur_line_r, cur_line_nxt;
  logic                done_r, done_nxt;
  logic [1:0]          status_r, status_nxt;

  logic                   busy;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [LINE_W+3:0]      line_prod;
  logic [PERIOD_W+3:0]    period_prod;
  logic [LINE_W-1:0]      line_sat;
  logic [PERIOD_W-1:0]    period_sat;
  field_st_t              line_st_f, period_st_f;
  logic [PERIOD_W-1:0]    ticks_dec;
  logic [TOTAL_W-1:0]     ptr_ext, ptr_inc;
  logic                   line_ok;
  logic                   ram_we, ram_re;
  logic [PTR_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [LINE_W-1:0]      fetch_line;
  logic [PERIOD_W-1:0]    fetch_period;
  logic                   need_fetch;

  function automatic field_st_t field_next(field_st_t st, logic [7:0] c);
    field_st_t r;
    logic      blank;
    blank = (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
    if (st == FS_DONE) begin
      r = FS_DONE;
    end else if (c inside {[CH_ZERO:CH_NINE]}) begin
      r = FS_DIGITS;
    end else if (st == FS_WAIT && blank) begin
      r = FS_WAIT;
    end else if (st == FS_WAIT && c == CH_PLUS) begin
      r = FS_DIGITS;
    end else begin
      r = FS_DONE;
    end
    return r;
  endfunction

  // digit accumulation with saturation
  assign is_digit    = in_data.program_byte inside {[CH_ZERO:CH_NINE]};
  assign digit       = in_data.program_byte[3:0];
  assign line_prod   = (LINE_W+4)'(line_acc_r) * (LINE_W+4)'(10) + (LINE_W+4)'(digit);
  assign period_prod = (PERIOD_W+4)'(period_acc_r) * (PERIOD_W+4)'(10)
                       + (PERIOD_W+4)'(digit);
  assign line_sat    = (line_prod > (LINE_W+4)'({LINE_W{1'b1}})) ? {LINE_W{1'b1}}
                       : line_prod[LINE_W-1:0];
  assign period_sat  = (period_prod > (PERIOD_W+4)'({PERIOD_W{1'b1}})) ? {PERIOD_W{1'b1}}
                       : period_prod[PERIOD_W-1:0];
  assign line_st_f   = field_next(line_st_r, in_data.program_byte);
  assign period_st_f = field_next(period_st_r, in_data.program_byte);

  assign busy      = (mode_r != MODE_IDLE);
  assign ticks_dec = (ticks_r != '0) ? ticks_r - PERIOD_W'(1) : '0;
  assign ptr_ext   = TOTAL_W'(ptr_r);
  assign ptr_inc   = ptr_ext + TOTAL_W'(1);
  assign line_ok   = (line_acc_r >= LINE_W'(1)) && (line_acc_r <= LINE_W'(ACTUATORS));

  assign fetch_line   = ram_rdata[ENTRY_W-1:PERIOD_W];
  assign fetch_period = ram_rdata[PERIOD_W-1:0];

  always_comb begin
    total_nxt      = total_r;
    line_acc_nxt   = line_acc_r;
    period_acc_nxt = period_acc_r;
    period_sel_nxt = period_sel_r;
    line_st_nxt    = line_st_r;
    period_st_nxt  = period_st_r;
    mode_nxt       = mode_r;
    ptr_nxt        = ptr_r;
    ticks_nxt      = ticks_r;
    cur_line_nxt   = cur_line_r;
    done_nxt       = done_r;
    status_nxt     = status_r;
    need_fetch     = 1'b0;
    ram_we         = 1'b0;
    ram_raddr      = ptr_r;

    if (cmd_i.accept) begin
      done_nxt   = 1'b0;
      status_nxt = ST_OK;
      if (in_data.kind != KIND_TICK && busy) begin
        status_nxt = ST_BUSY;
      end else begin
        case (in_data.kind)
          KIND_LOAD: begin
            total_nxt      = '0;
            line_acc_nxt   = '0;
            period_acc_nxt = '0;
            period_sel_nxt = 1'b0;
            line_st_nxt    = FS_WAIT;
            period_st_nxt  = FS_WAIT;
          end
          KIND_BYTE: begin
            if (in_data.program_byte == CH_OPEN) begin
              line_acc_nxt   = '0;
              period_acc_nxt = '0;
              period_sel_nxt = 1'b0;
              line_st_nxt    = FS_WAIT;
              period_st_nxt  = FS_WAIT;
            end else if (in_data.program_byte == CH_COLON) begin
              period_sel_nxt = 1'b1;
            end else if (in_data.program_byte == CH_CLOSE) begin
              if (total_r >= TOTAL_W'(MAX_PHASES)) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                total_nxt = total_r + TOTAL_W'(1);
                if (!line_ok) begin
                  status_nxt = ST_RANGE;
                end
              end
            end else if (period_sel_r) begin
              period_st_nxt = period_st_f;
              if (period_st_r != FS_DONE && is_digit) begin
                period_acc_nxt = period_sat;
              end
            end else begin
              line_st_nxt = line_st_f;
              if (line_st_r != FS_DONE && is_digit) begin
                line_acc_nxt = line_sat;
              end
            end
          end
          KIND_START: begin
            ptr_nxt = '0;
            if (total_r == '0) begin
              done_nxt = 1'b1;
            end else begin
              need_fetch = 1'b1;
              ram_raddr  = '0;
            end
          end
          KIND_TICK: begin
            if (busy) begin
              ticks_nxt = ticks_dec;
              if (ticks_dec == '0) begin
                if (mode_r == MODE_PHASE && delay_r != '0) begin
                  mode_nxt  = MODE_GAP;
                  ticks_nxt = delay_r;
                end else if (ptr_inc < total_r) begin
                  // next phase: entry comes back from the table in the following cycle
                  ptr_nxt    = ptr_inc[PTR_W-1:0];
                  need_fetch = 1'b1;
                  ram_raddr  = ptr_inc[PTR_W-1:0];
                end else begin
                  mode_nxt  = MODE_IDLE;
                  ticks_nxt = '0;
                  done_nxt  = 1'b1;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd_i.fetch_load) begin
      mode_nxt     = MODE_PHASE;
      cur_line_nxt = fetch_line;
      ticks_nxt    = (fetch_period != '0) ? fetch_period : PERIOD_W'(1);
    end
  end

  assign ram_re = need_fetch;
  assign sts_o.need_fetch = need_fetch;

  tops_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PHASES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total_r[PTR_W-1:0]),
    .wdata ({line_acc_r, period_acc_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      line_acc_r   <= '0;
      period_acc_r <= '0;
      period_sel_r <= 1'b0;
      line_st_r    <= FS_WAIT;
      period_st_r  <= FS_WAIT;
      mode_r       <= MODE_IDLE;
      ptr_r        <= '0;
      ticks_r      <= '0;
      delay_r      <= '0;
      done_r       <= 1'b0;
      status_r     <= ST_OK;
    end else begin
      total_r      <= total_nxt;
      line_acc_r   <= line_acc_nxt;
      period_acc_r <= period_acc_nxt;
      period_sel_r <= period_sel_nxt;
      line_st_r    <= line_st_nxt;
      period_st_r  <= period_st_nxt;
      mode_r       <= mode_nxt;
      ptr_r        <= ptr_nxt;
      ticks_r      <= ticks_nxt;
      done_r       <= done_nxt;
      status_r     <= status_nxt;
      if (cfg_we) begin
        delay_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_line_r <= cur_line_nxt;
  end

  // result fields straight from state
  always_comb begin
    res_o = '0;
    if (mode_r == MODE_PHASE && cur_line_r >= LINE_W'(1)
        && cur_line_r <= LINE_W'(ACTUATORS)) begin
      res_o.actuator_drive = DRIVE_W'(1) << (cur_line_r - LINE_W'(1));
    end
    res_o.busy_res      = busy;
    res_o.run_done      = done_r;
    res_o.current_phase = 6'(ptr_r);
    res_o.stored_phases = 7'(total_r);
    res_o.status        = status_r;
  end

  `TOPS_ASSERT(a_total_bound, total_r <= TOTAL_W'(MAX_PHASES), "phase count above table size")
  `TOPS_ASSERT(a_ptr_in_table, busy |-> ptr_ext < total_r, "running phase beyond stored phases")
  `TOPS_ASSERT(a_fetch_arms, cmd_i.fetch_load |=> mode_r == MODE_PHASE && ticks_r != '0, "phase entry left no ticks")

endmodule

[rtl/tops_ctrl.sv]
// ----------------------------------------------------------------------------
// tops_ctrl
// controller: accept, table fetch and result hand-off sequencing
// ----------------------------------------------------------------------------
`include "timed_output_phase_sequencer_unit_defines.svh"

module tops_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tops_pkg::dp_sts_t sts_i,
  output tops_pkg::dp_cmd_t cmd_o
);
  import tops_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_OUT   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign cmd_o.accept     = in_valid && (state_r == S_IDLE);
  assign cmd_o.fetch_load = (state_r == S_FETCH);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts_i.need_fetch ? S_FETCH : S_OUT;
        end
      end
      S_FETCH: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TOPS_ASSERT(a_fetch_after_accept, cmd_o.fetch_load |-> $past(cmd_o.accept), "fetch without accepted beat")

endmodule
